### hdl/ipp_pkg.sv
// Shared types, character codes and helpers for the IP address text parser.
// No dependencies; imported by the core and the top level.
package ipp_pkg;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_DOT   = 8'h2e;
	localparam logic [7:0] CH_COLON = 8'h3a;

	localparam logic [1:0] FAM_V4 = 2'd0;
	localparam logic [1:0] FAM_V6 = 2'd1;

	localparam logic [7:0]  V4_OCTET_MAX = 8'd255;
	localparam int unsigned V6_GROUPS    = 8;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_MALFORMED = 2'd1,
		ST_FAMILY    = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		PH_START  = 3'd0,
		PH_COLON1 = 3'd1,
		PH_GAP    = 3'd2,
		PH_GROUP  = 3'd4,
		PH_SEP    = 3'd5
	} phase_t;

	typedef struct packed {
		logic       ok;
		logic [3:0] val;
	} hex_t;

	typedef struct packed {
		status_t     status;
		logic [63:0] addr_hi;
		logic [63:0] addr_lo;
	} result_t;

	function automatic hex_t hex_digit(input logic [7:0] c);
		hex_t h;
		h.ok  = 1'b1;
		h.val = c[3:0];
		if (c inside {[8'h30:8'h39]}) begin
			h.val = c[3:0];
		end else if (c inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
			h.val = c[3:0] + 4'd9;
		end else begin
			h.ok = 1'b0;
		end
		return h;
	endfunction

endpackage

### hdl/ipp_text_if.sv
// Character channel of the IP address text parser: valid/ready plus one
// character and the address family. No dependencies.
interface ipp_text_if;
	logic       valid;
	logic       ready;
	logic [7:0] ch;
	logic [1:0] func;

	modport source (output valid, output ch, output func, input ready);
	modport sink (input valid, input ch, input func, output ready);
endinterface

### hdl/ipp_result_if.sv
// Result channel of the IP address text parser: valid/ready plus status
// and the 16 address bytes. No dependencies.
interface ipp_result_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [63:0] addr_hi;
	logic [63:0] addr_lo;

	modport source (output valid, output status, output addr_hi, output addr_lo, input ready);
	modport sink (input valid, input status, input addr_hi, input addr_lo, output ready);
endinterface

### hdl/ipp_core.sv
// Parse state of the IP address text parser: per-character update and
// end-of-string result assembly. Depends on ipp_pkg.
module ipp_core import ipp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [7:0] ch,
	input  logic [1:0] func,
	output result_t    res
);

	logic         first_q;
	logic [1:0]   fam_q;
	logic         failed_q;
	phase_t       phase_q;
	logic [15:0]  digit_q;
	logic         seen_q;
	logic [3:0]   count_q;
	logic [3:0]   gap_pos_q;
	logic         gap_q;
	logic [127:0] tail_q;
	logic [15:0]  head_q [V6_GROUPS];

	logic [1:0]   fam_c;
	logic         failed_c;
	phase_t       phase_c;
	logic [15:0]  digit_c;
	logic         seen_c;
	logic [3:0]   count_c;
	logic [3:0]   gap_pos_c;
	logic         gap_c;
	logic [127:0] tail_c;

	logic         first_n;
	logic         failed_n;
	phase_t       phase_n;
	logic [15:0]  digit_n;
	logic         seen_n;
	logic [3:0]   count_n;
	logic [3:0]   gap_pos_n;
	logic         gap_n;
	logic [127:0] tail_n;
	logic         we;
	logic [2:0]   widx;

	hex_t         h;
	logic [11:0]  v4_sum;

	// Current state, with string-start values on the first character
	always_comb begin
		if (first_q) begin
			fam_c     = func;
			failed_c  = 1'b0;
			phase_c   = PH_START;
			digit_c   = '0;
			seen_c    = 1'b0;
			count_c   = '0;
			gap_pos_c = '0;
			gap_c     = 1'b0;
			tail_c    = '0;
		end else begin
			fam_c     = fam_q;
			failed_c  = failed_q;
			phase_c   = phase_q;
			digit_c   = digit_q;
			seen_c    = seen_q;
			count_c   = count_q;
			gap_pos_c = gap_pos_q;
			gap_c     = gap_q;
			tail_c    = tail_q;
		end
	end

	assign h      = hex_digit(ch);
	assign v4_sum = 12'(digit_c[7:0]) * 12'd10 + {8'd0, ch[3:0]};

	always_comb begin
		first_n   = first_q;
		failed_n  = failed_c;
		phase_n   = phase_c;
		digit_n   = digit_c;
		seen_n    = seen_c;
		count_n   = count_c;
		gap_pos_n = gap_pos_c;
		gap_n     = gap_c;
		tail_n    = tail_c;
		we        = 1'b0;
		widx      = count_c[2:0];
		if (ch == CH_NUL) begin
			first_n = 1'b1;
		end else begin
			first_n = 1'b0;
			if (!fam_c[1] && !failed_c) begin
				if (fam_c == FAM_V4) begin
					if (ch inside {[8'h30:8'h39]}) begin
						if (v4_sum > {4'd0, V4_OCTET_MAX}) begin
							failed_n = 1'b1;
						end else begin
							digit_n = {4'd0, v4_sum};
							seen_n  = 1'b1;
						end
					end else if (ch == CH_DOT) begin
						if (!seen_c || count_c >= 4'd3) begin
							failed_n = 1'b1;
						end else begin
							we      = 1'b1;
							count_n = count_c + 4'd1;
							digit_n = '0;
							seen_n  = 1'b0;
						end
					end else begin
						failed_n = 1'b1;
					end
				end else begin
					case (phase_c)
						PH_START, PH_GAP, PH_SEP: begin
							if (h.ok) begin
								if (count_c >= 4'(V6_GROUPS)) begin
									failed_n = 1'b1;
								end else begin
									digit_n = {12'd0, h.val};
									seen_n  = 1'b1;
									phase_n = PH_GROUP;
								end
							end else if (ch == CH_COLON && phase_c == PH_START) begin
								phase_n = PH_COLON1;
							end else if (ch == CH_COLON && phase_c == PH_SEP && !gap_c) begin
								gap_n     = 1'b1;
								gap_pos_n = count_c;
								phase_n   = PH_GAP;
							end else begin
								failed_n = 1'b1;
							end
						end
						PH_COLON1: begin
							if (ch == CH_COLON) begin
								gap_n     = 1'b1;
								gap_pos_n = '0;
								phase_n   = PH_GAP;
							end else begin
								failed_n = 1'b1;
							end
						end
						PH_GROUP: begin
							if (h.ok) begin
								if (digit_c[15:12] != 4'd0) begin
									failed_n = 1'b1;
								end else begin
									digit_n = {digit_c[11:0], h.val};
								end
							end else if (ch == CH_COLON) begin
								if (gap_c) begin
									tail_n = {tail_c[111:0], digit_c};
								end else begin
									we = 1'b1;
								end
								count_n = count_c + 4'd1;
								digit_n = '0;
								seen_n  = 1'b0;
								phase_n = PH_SEP;
							end else begin
								failed_n = 1'b1;
							end
						end
						default: begin
							failed_n = 1'b1;
						end
					endcase
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q   <= 1'b1;
			fam_q     <= FAM_V4;
			failed_q  <= 1'b0;
			phase_q   <= PH_START;
			digit_q   <= '0;
			seen_q    <= 1'b0;
			count_q   <= '0;
			gap_pos_q <= '0;
			gap_q     <= 1'b0;
			tail_q    <= '0;
		end else if (step) begin
			first_q   <= first_n;
			fam_q     <= fam_c;
			failed_q  <= failed_n;
			phase_q   <= phase_n;
			digit_q   <= digit_n;
			seen_q    <= seen_n;
			count_q   <= count_n;
			gap_pos_q <= gap_pos_n;
			gap_q     <= gap_n;
			tail_q    <= tail_n;
		end
	end

	always_ff @(posedge clk) begin
		if (step && we) begin
			head_q[widx] <= digit_c;
		end
	end

	// End-of-string assembly
	logic         in_group;
	logic [3:0]   cnt_e;
	logic [127:0] tail_e;
	logic [127:0] words;
	logic [15:0]  head_w;

	assign in_group = (phase_c == PH_GROUP);
	assign cnt_e    = count_c + {3'd0, in_group};
	assign tail_e   = (in_group && gap_c) ? {tail_c[111:0], digit_c} : tail_c;

	always_comb begin
		words = tail_e;
		for (int p = 0; p < V6_GROUPS; p++) begin
			head_w = head_q[p];
			if (p == V6_GROUPS - 1 && in_group && !gap_c) begin
				head_w = digit_c;
			end
			if (!gap_c || 4'(p) < gap_pos_c) begin
				words[127 - 16 * p -: 16] = words[127 - 16 * p -: 16] | head_w;
			end
		end
	end

	always_comb begin
		res.status  = ST_OK;
		res.addr_hi = '0;
		res.addr_lo = '0;
		if (fam_c[1]) begin
			res.status = ST_FAMILY;
		end else if (failed_c) begin
			res.status = ST_MALFORMED;
		end else if (fam_c == FAM_V4) begin
			if (!seen_c || count_c != 4'd3) begin
				res.status = ST_MALFORMED;
			end else begin
				res.addr_hi = {head_q[0][7:0], head_q[1][7:0], head_q[2][7:0],
					digit_c[7:0], 32'd0};
			end
		end else if (in_group && count_c >= 4'(V6_GROUPS)) begin
			res.status = ST_MALFORMED;
		end else if (!in_group && phase_c != PH_GAP) begin
			res.status = ST_MALFORMED;
		end else if (gap_c ? (cnt_e >= 4'(V6_GROUPS)) : (cnt_e != 4'(V6_GROUPS))) begin
			res.status = ST_MALFORMED;
		end else begin
			res.addr_hi = words[127:64];
			res.addr_lo = words[63:0];
		end
	end

endmodule

### hdl/ip_address_text_parser.sv
// Path: a terminator beat is held in the input register, then its result
// is held in the result register until the sink takes it.
// Throughput: one character per cycle; a terminator waits for a held result.
// Reset: clears both valid flags and the parse state; the first character
// after reset starts a new string.
module ip_address_text_parser import ipp_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	ipp_text_if.sink     text,
	ipp_result_if.source result
);

	logic       valid_s1;
	logic [7:0] ch_s1;
	logic [1:0] func_s1;
	logic       res_valid_q;
	result_t    res_q;
	result_t    res_c;
	logic       advance;
	logic       term;

	assign term       = (ch_s1 == CH_NUL);
	assign advance    = valid_s1 && (!term || !res_valid_q || result.ready);
	assign text.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (text.ready) begin
			valid_s1 <= text.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (text.ready && text.valid) begin
			ch_s1   <= text.ch;
			func_s1 <= text.func;
		end
	end

	ipp_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.ch     (ch_s1),
		.func   (func_s1),
		.res    (res_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance && term) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && term) begin
			res_q <= res_c;
		end
	end

	assign result.valid   = res_valid_q;
	assign result.status  = res_q.status;
	assign result.addr_hi = res_q.addr_hi;
	assign result.addr_lo = res_q.addr_lo;

endmodule

### tb/tb.sv
`timescale 1ns / 100ps
// Testbench for ip_address_text_parser: streams address strings and checks every result beat.
// Depends on ipp_pkg, ipp_text_if, ipp_result_if and the parser top level.

class addr_scoreboard;
	bit          first_pending = 1'b1;
	logic [1:0]  family;
	bit          failed;
	ipp_pkg::phase_t phase;
	logic [15:0] digit_value;
	bit          digit_seen;
	int          group_count;
	int          gap_pos;
	bit          gap_valid;
	logic [15:0] groups[8];

	ipp_pkg::result_t expected_addrs[$];
	int errors;

	function int unsigned hex_value(logic [7:0] c);
		if (c >= "0" && c <= "9") return c - "0";
		if (c >= "a" && c <= "f") return c - "a" + 10;
		if (c >= "A" && c <= "F") return c - "A" + 10;
		return 16;
	endfunction

	function void v4_char(logic [7:0] c);
		int unsigned v;
		if (c >= "0" && c <= "9") begin
			v = digit_value * 10 + (c - "0");
			if (v > 255) begin
				failed = 1'b1;
			end else begin
				digit_value = v[15:0];
				digit_seen = 1'b1;
			end
		end else if (c == ipp_pkg::CH_DOT) begin
			if (!digit_seen || group_count >= 3) begin
				failed = 1'b1;
			end else begin
				groups[group_count] = digit_value;
				group_count++;
				digit_value = '0;
				digit_seen = 1'b0;
			end
		end else begin
			failed = 1'b1;
		end
	endfunction

	function void v6_start_group(int unsigned h);
		if (group_count >= 8) begin
			failed = 1'b1;
		end else begin
			digit_value = h[15:0];
			digit_seen = 1'b1;
			phase = ipp_pkg::PH_GROUP;
		end
	endfunction

	function void v6_char(logic [7:0] c);
		int unsigned h;
		int unsigned v;
		h = hex_value(c);
		case (phase)
			ipp_pkg::PH_START: begin
				if (c == ipp_pkg::CH_COLON) phase = ipp_pkg::PH_COLON1;
				else if (h < 16) v6_start_group(h);
				else failed = 1'b1;
			end
			ipp_pkg::PH_COLON1: begin
				if (c == ipp_pkg::CH_COLON) begin
					gap_valid = 1'b1;
					gap_pos = 0;
					phase = ipp_pkg::PH_GAP;
				end else begin
					failed = 1'b1;
				end
			end
			ipp_pkg::PH_GAP, ipp_pkg::PH_SEP: begin
				if (h < 16) begin
					v6_start_group(h);
				end else if (c == ipp_pkg::CH_COLON && phase == ipp_pkg::PH_SEP && !gap_valid) begin
					gap_valid = 1'b1;
					gap_pos = group_count;
					phase = ipp_pkg::PH_GAP;
				end else begin
					failed = 1'b1;
				end
			end
			ipp_pkg::PH_GROUP: begin
				if (h < 16) begin
					v = {digit_value, 4'h0} | h;
					if (v > 32'hffff) failed = 1'b1;
					else digit_value = v[15:0];
				end else if (c == ipp_pkg::CH_COLON) begin
					groups[group_count] = digit_value;
					group_count++;
					digit_value = '0;
					digit_seen = 1'b0;
					phase = ipp_pkg::PH_SEP;
				end else begin
					failed = 1'b1;
				end
			end
			default: failed = 1'b1;
		endcase
	endfunction

	function ipp_pkg::result_t finish_address();
		ipp_pkg::result_t r;
		logic [15:0] w[8];
		int pos;
		r.status = ipp_pkg::ST_MALFORMED;
		r.addr_hi = '0;
		r.addr_lo = '0;
		if (family >= 2'd2) begin
			r.status = ipp_pkg::ST_FAMILY;
			return r;
		end
		if (failed) return r;
		if (family == ipp_pkg::FAM_V4) begin
			if (!digit_seen || group_count != 3) return r;
			r.status = ipp_pkg::ST_OK;
			r.addr_hi = {groups[0][7:0], groups[1][7:0], groups[2][7:0], digit_value[7:0],
				32'h0};
			return r;
		end
		if (phase == ipp_pkg::PH_GROUP) begin
			if (group_count >= 8) return r;
			groups[group_count] = digit_value;
			group_count++;
		end else if (phase != ipp_pkg::PH_GAP) begin
			return r;
		end
		if (gap_valid ? (group_count >= 8) : (group_count != 8)) return r;
		foreach (w[i]) w[i] = '0;
		for (int i = 0; i < group_count; i++) begin
			pos = (gap_valid && i >= gap_pos) ? i + (8 - group_count) : i;
			w[pos] = groups[i];
		end
		r.status = ipp_pkg::ST_OK;
		r.addr_hi = {w[0], w[1], w[2], w[3]};
		r.addr_lo = {w[4], w[5], w[6], w[7]};
		return r;
	endfunction

	function void note_char(logic [7:0] c, logic [1:0] fn);
		if (first_pending) begin
			family = fn;
			first_pending = 1'b0;
			failed = 1'b0;
			phase = ipp_pkg::PH_START;
			digit_value = '0;
			digit_seen = 1'b0;
			group_count = 0;
			gap_pos = 0;
			gap_valid = 1'b0;
		end
		if (c == ipp_pkg::CH_NUL) begin
			expected_addrs.push_back(finish_address());
			first_pending = 1'b1;
		end else if (family < 2'd2 && !failed) begin
			if (family == ipp_pkg::FAM_V4) v4_char(c);
			else v6_char(c);
		end
	endfunction

	function void check_result(logic [1:0] st, logic [63:0] hi, logic [63:0] lo);
		ipp_pkg::result_t exp_r;
		if (expected_addrs.size() == 0) begin
			errors++;
			if (errors <= 10)
				$display("tb: unexpected result beat status=%0d addr=%h_%h", st, hi, lo);
			return;
		end
		exp_r = expected_addrs.pop_front();
		if (exp_r.status !== st || exp_r.addr_hi !== hi || exp_r.addr_lo !== lo) begin
			errors++;
			if (errors <= 10)
				$display("tb: mismatch expected status=%0d addr=%h_%h, got status=%0d addr=%h_%h",
					exp_r.status, exp_r.addr_hi, exp_r.addr_lo, st, hi, lo);
		end
	endfunction
endclass

module tb;
	import ipp_pkg::*;

	localparam logic [1:0] FAM_RSVD_A = 2'd2;
	localparam logic [1:0] FAM_RSVD_B = 2'd3;
	localparam int STUCK_LIMIT = 2000;
	localparam int LONG_HOLD   = 300;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	ipp_text_if   txt ();
	ipp_result_if res ();

	ip_address_text_parser dut (
		.clk    (clk),
		.arst_n (arst_n),
		.text   (txt),
		.result (res)
	);

	addr_scoreboard sb = new;

	int src_idle_pct = 0;
	int snk_stall_pct = 0;
	bit hold_off_req = 1'b0;
	int chars_sent = 0;
	int strings_sent = 0;

	always #5 clk = ~clk;

	task automatic send_char(logic [7:0] c, logic [1:0] fn);
		while (src_idle_pct > 0 && $urandom_range(99) < src_idle_pct) begin
			txt.valid <= 1'b0;
			@(negedge clk);
		end
		txt.valid <= 1'b1;
		txt.ch <= c;
		txt.func <= fn;
		do @(posedge clk); while (txt.ready !== 1'b1);
		sb.note_char(c, fn);
		chars_sent++;
		@(negedge clk);
	endtask

	task automatic send_text(string s, logic [1:0] fam);
		logic [7:0] c;
		for (int i = 0; i <= s.len(); i++) begin
			c = (i < s.len()) ? s[i] : CH_NUL;
			send_char(c, (i == 0) ? fam : 2'($urandom_range(3)));
		end
		strings_sent++;
	endtask

	task automatic wait_drain();
		txt.valid <= 1'b0;
		do @(posedge clk); while (sb.expected_addrs.size() != 0);
		@(negedge clk);
	endtask

	function automatic logic [7:0] pick_char();
		case ($urandom_range(5))
			0: return 8'($urandom_range("0", "9"));
			1: return $urandom_range(1) ? 8'($urandom_range("a", "f")) : 8'($urandom_range("A", "F"));
			2: return CH_COLON;
			3: return CH_DOT;
			default: return 8'($urandom_range(1, 255));
		endcase
	endfunction

	function automatic string v4_text(int n_oct, int max_val);
		string s;
		s = "";
		for (int i = 0; i < n_oct; i++) begin
			if (i > 0) s = {s, "."};
			repeat ($urandom_range(3) == 0 ? $urandom_range(1, 2) : 0) s = {s, "0"};
			s = {s, $sformatf("%0d", $urandom_range(max_val))};
		end
		return s;
	endfunction

	function automatic string hex_group();
		string g;
		int unsigned v;
		v = ($urandom_range(3) == 0) ? $urandom_range(15) : $urandom_range(16'hffff);
		g = $sformatf("%0h", v);
		if (g.len() < 4 && $urandom_range(2) == 0) g = {"0", g};
		for (int i = 0; i < g.len(); i++)
			if (g[i] >= "a" && $urandom_range(1)) g[i] = g[i] - 8'h20;
		return g;
	endfunction

	function automatic string v6_text(int n, bit gap);
		string s;
		int gp;
		s = "";
		gp = gap ? $urandom_range(n) : -1;
		for (int i = 0; i < n; i++) begin
			if (i == gp) s = {s, "::"};
			else if (i > 0) s = {s, ":"};
			s = {s, hex_group()};
		end
		if (gp == n) s = {s, "::"};
		return s;
	endfunction

	function automatic string mutate(string s);
		int pos;
		string c;
		c = $sformatf("%c", pick_char());
		if (s.len() == 0) return c;
		pos = $urandom_range(s.len() - 1);
		case ($urandom_range(2))
			0: s = {s.substr(0, pos - 1), c, s.substr(pos + 1, s.len() - 1)};
			1: s = {s.substr(0, pos - 1), s.substr(pos + 1, s.len() - 1)};
			default: s = {s.substr(0, pos - 1), c, s.substr(pos, s.len() - 1)};
		endcase
		return s;
	endfunction

	task automatic run_random(int n_chars, int n_strings);
		int chars_goal;
		int strings_goal;
		int kind;
		int n;
		string s;
		logic [1:0] fam;
		chars_goal = chars_sent + n_chars;
		strings_goal = strings_sent + n_strings;
		while (chars_sent < chars_goal || strings_sent < strings_goal) begin
			kind = $urandom_range(99);
			if (kind < 30) begin
				fam = FAM_V4;
				s = v4_text(4, 255);
			end else if (kind < 62) begin
				fam = FAM_V6;
				n = $urandom_range(8);
				s = (n == 8) ? v6_text(8, 1'b0) : v6_text(n, 1'b1);
			end else if (kind < 70) begin
				fam = FAM_V4;
				s = v4_text($urandom_range(3, 5), 999);
			end else if (kind < 76) begin
				fam = FAM_V6;
				s = $urandom_range(1) ? v6_text(9, 1'b0) : v6_text(8, 1'b1);
			end else if (kind < 88) begin
				fam = $urandom_range(1) ? FAM_V4 : FAM_V6;
				s = (fam == FAM_V4) ? v4_text(4, 255) : v6_text($urandom_range(7), 1'b1);
				s = mutate(s);
			end else if (kind < 95) begin
				fam = 2'($urandom_range(3));
				s = "";
				repeat ($urandom_range(6)) s = {s, $sformatf("%c", pick_char())};
			end else begin
				fam = $urandom_range(1) ? FAM_RSVD_A : FAM_RSVD_B;
				s = $urandom_range(1) ? v4_text(4, 255) : v6_text(8, 1'b0);
			end
			send_text(s, fam);
		end
	endtask

	initial begin
		res.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				res.ready <= 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
			end
			res.ready <= !(snk_stall_pct > 0 && $urandom_range(99) < snk_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && res.valid === 1'b1 && res.ready === 1'b1)
			sb.check_result(res.status, res.addr_hi, res.addr_lo);
	end

	initial begin
		int stuck = 0;
		while (stuck < STUCK_LIMIT) begin
			@(posedge clk);
			if ((txt.valid === 1'b1 && txt.ready === 1'b1) ||
				(res.valid === 1'b1 && res.ready === 1'b1))
				stuck = 0;
			else
				stuck++;
		end
		$display("tb: done, errors");
		$finish;
	end

	initial begin
		txt.valid = 1'b0;
		txt.ch = CH_NUL;
		txt.func = FAM_V4;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_text("", FAM_V4);
		send_text("", FAM_V6);
		send_text("::", FAM_V6);
		send_text("255.0.09.1", FAM_V4);
		send_text("256.1.1.1", FAM_V4);
		send_text("fFfF:0::A", FAM_V6);
		send_text("12345::", FAM_V6);
		send_text("1:2:3:4:5:6:7:8", FAM_V6);
		send_text("1:2:3:4:5:6:7:8:9", FAM_V6);
		send_text("1::2::3", FAM_V6);
		send_text("1::2:3.4.5.6", FAM_V6);
		send_text("1.2.3.4", FAM_RSVD_A);
		send_text("::", FAM_RSVD_B);

		hold_off_req = 1'b1;
		run_random(40, 2);
		wait_drain();
		run_random(40, 2);

		for (int ph = 1; ph < 4; ph++) begin
			wait_drain();
			src_idle_pct = (ph == 1) ? 46 : (ph == 3) ? 25 : 0;
			snk_stall_pct = (ph == 2) ? 46 : (ph == 3) ? 25 : 0;
			run_random(70, 4);
		end

		wait_drain();
		repeat (10) @(posedge clk);
		if (sb.errors == 0 && sb.expected_addrs.size() == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end
endmodule
